// ===== src/ole_pkg.sv =====
// Package for the ordered list engine: sizes, command and status codes,
// and the write request word passed to the entry store. No dependencies.
package ole_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W     = 3;
    localparam int ST_W     = 2;
    localparam int LEN_W    = 5;

    localparam logic [OP_W-1:0] OP_INS_FRONT  = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_END    = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_BEFORE = 3'd2;
    localparam logic [OP_W-1:0] OP_INS_AFTER  = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_HEAD   = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_TAIL   = 3'd5;
    localparam logic [OP_W-1:0] OP_DEL_KEY    = 3'd6;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] data;
    } ole_wr_t;

endpackage

// ===== src/ordered_list_engine_unit.sv =====
// Ordered list engine top level: command sequencer with key scan and
// entry shift over a store with one write and one read port. Depends on ole_pkg and ole_store.
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+---------------------------------
//  command  | operation, key, new_value      | taken when start & !busy
//  result   | status, length                 | valid one cycle while done high
//
// Front and end inserts pass through the move and place states, head and tail deletes
// through the move state alone, and keyed commands first scan for the key; all of them
// move entries one per cycle. Rejected commands never raise busy; each result is
// strobed in the first cycle after acceptance with busy low.
// Reset empties the list at once; stored entries are left as they are.
// The result is strobed for one cycle and cannot be held off.
module ordered_list_engine_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ole_pkg::OP_W-1:0]    operation,
    input  logic [ole_pkg::DATA_W-1:0]  key,
    input  logic [ole_pkg::DATA_W-1:0]  new_value,
    output logic                        done,
    output logic [ole_pkg::ST_W-1:0]    status,
    output logic [ole_pkg::LEN_W-1:0]   length
);
    import ole_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE,
        S_PLACE
    } state_t;

    state_t            state_reg;
    logic [OP_W-1:0]   op_reg;
    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] val_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  src_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic              ins_reg;
    logic              pend_reg;
    logic [IDX_W-1:0]  wdst_reg;
    logic              chk_vld_reg;
    logic [CNT_W-1:0]  chk_idx_reg;
    logic              done_reg;
    logic [ST_W-1:0]   status_reg;
    logic [LEN_W-1:0]  length_reg;

    ole_wr_t           wr;
    logic [DATA_W-1:0] rd_data;
    logic              full_c;
    logic              match_c;
    logic [CNT_W-1:0]  last_c;
    logic [CNT_W-1:0]  hit_pos_c;

    ole_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (src_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign full_c    = (count_reg >= CNT_W'(CAPACITY));
    assign match_c   = (rd_data == key_reg);
    assign last_c    = count_reg - CNT_W'(1);
    assign hit_pos_c = (op_reg == OP_INS_AFTER) ? chk_idx_reg + CNT_W'(1) : chk_idx_reg;

    always_comb
    begin
        wr.en   = 1'b0;
        wr.addr = wdst_reg;
        wr.data = rd_data;
        if (state_reg == S_MOVE && pend_reg)
        begin
            wr.en = 1'b1;
        end
        else if (state_reg == S_PLACE)
        begin
            wr.en   = 1'b1;
            wr.addr = pos_reg[IDX_W-1:0];
            wr.data = val_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            rem_reg     <= '0;
            pend_reg    <= 1'b0;
            chk_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
            status_reg  <= ST_OK;
            length_reg  <= '0;
            op_reg      <= '0;
            key_reg     <= '0;
            val_reg     <= '0;
            pos_reg     <= '0;
            src_reg     <= '0;
            ins_reg     <= 1'b0;
            wdst_reg    <= '0;
            chk_idx_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    chk_vld_reg <= 1'b0;
                    pend_reg    <= 1'b0;
                    if (start)
                    begin
                        op_reg  <= operation;
                        key_reg <= key;
                        val_reg <= new_value;
                        case (operation)
                            OP_INS_FRONT, OP_INS_END:
                            begin
                                if (full_c)
                                begin
                                    done_reg   <= 1'b1;
                                    status_reg <= ST_FULL;
                                    length_reg <= LEN_W'(count_reg);
                                end
                                else
                                begin
                                    pos_reg   <= (operation == OP_INS_FRONT) ? '0 : count_reg;
                                    rem_reg   <= (operation == OP_INS_FRONT) ? count_reg : '0;
                                    src_reg   <= last_c;
                                    ins_reg   <= 1'b1;
                                    state_reg <= S_MOVE;
                                end
                            end
                            OP_INS_BEFORE, OP_INS_AFTER, OP_DEL_KEY:
                            begin
                                if (count_reg == '0)
                                begin
                                    done_reg   <= 1'b1;
                                    status_reg <= ST_EMPTY;
                                    length_reg <= LEN_W'(count_reg);
                                end
                                else if (full_c && operation != OP_DEL_KEY)
                                begin
                                    done_reg   <= 1'b1;
                                    status_reg <= ST_FULL;
                                    length_reg <= LEN_W'(count_reg);
                                end
                                else
                                begin
                                    src_reg   <= '0;
                                    rem_reg   <= count_reg;
                                    state_reg <= S_SCAN;
                                end
                            end
                            OP_DEL_HEAD, OP_DEL_TAIL:
                            begin
                                if (count_reg == '0)
                                begin
                                    done_reg   <= 1'b1;
                                    status_reg <= ST_EMPTY;
                                    length_reg <= LEN_W'(count_reg);
                                end
                                else
                                begin
                                    pos_reg   <= (operation == OP_DEL_HEAD) ? '0 : last_c;
                                    rem_reg   <= (operation == OP_DEL_HEAD) ? last_c : '0;
                                    src_reg   <= (operation == OP_DEL_HEAD) ? CNT_W'(1) : count_reg;
                                    ins_reg   <= 1'b0;
                                    state_reg <= S_MOVE;
                                end
                            end
                            default:
                            begin
                                done_reg   <= 1'b1;
                                status_reg <= ST_OK;
                                length_reg <= LEN_W'(count_reg);
                            end
                        endcase
                    end
                end

                S_SCAN:
                begin
                    // issue the next read while the previous one is compared
                    if (rem_reg != '0)
                    begin
                        chk_vld_reg <= 1'b1;
                        chk_idx_reg <= src_reg;
                        src_reg     <= src_reg + CNT_W'(1);
                        rem_reg     <= rem_reg - CNT_W'(1);
                    end
                    else
                    begin
                        chk_vld_reg <= 1'b0;
                    end
                    if (chk_vld_reg && match_c)
                    begin
                        chk_vld_reg <= 1'b0;
                        state_reg   <= S_MOVE;
                        if (op_reg == OP_DEL_KEY)
                        begin
                            pos_reg <= chk_idx_reg;
                            rem_reg <= last_c - chk_idx_reg;
                            src_reg <= chk_idx_reg + CNT_W'(1);
                            ins_reg <= 1'b0;
                        end
                        else
                        begin
                            pos_reg <= hit_pos_c;
                            rem_reg <= count_reg - hit_pos_c;
                            src_reg <= last_c;
                            ins_reg <= 1'b1;
                        end
                    end
                    else if (chk_vld_reg && chk_idx_reg == last_c)
                    begin
                        chk_vld_reg <= 1'b0;
                        done_reg    <= 1'b1;
                        status_reg  <= ST_NOTFOUND;
                        length_reg  <= LEN_W'(count_reg);
                        state_reg   <= S_IDLE;
                    end
                end

                S_MOVE:
                begin
                    if (rem_reg != '0)
                    begin
                        pend_reg <= 1'b1;
                        rem_reg  <= rem_reg - CNT_W'(1);
                        if (ins_reg)
                        begin
                            wdst_reg <= IDX_W'(src_reg + CNT_W'(1));
                            src_reg  <= src_reg - CNT_W'(1);
                        end
                        else
                        begin
                            wdst_reg <= IDX_W'(src_reg - CNT_W'(1));
                            src_reg  <= src_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                        if (ins_reg)
                        begin
                            state_reg <= S_PLACE;
                        end
                        else
                        begin
                            count_reg  <= last_c;
                            done_reg   <= 1'b1;
                            status_reg <= ST_OK;
                            length_reg <= LEN_W'(last_c);
                            state_reg  <= S_IDLE;
                        end
                    end
                end

                S_PLACE:
                begin
                    count_reg  <= count_reg + CNT_W'(1);
                    done_reg   <= 1'b1;
                    status_reg <= ST_OK;
                    length_reg <= LEN_W'(count_reg + CNT_W'(1));
                    state_reg  <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;
    assign length = length_reg;

endmodule

// ===== src/ole_store.sv =====
// Entry store: one write port, one read port with registered read data.
// Depends on ole_pkg.
module ole_store (
    input  logic                       clk,
    input  ole_pkg::ole_wr_t           wr,
    input  logic [ole_pkg::IDX_W-1:0]  rd_addr,
    output logic [ole_pkg::DATA_W-1:0] rd_data
);
    import ole_pkg::*;

    logic [DATA_W-1:0] mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/ole_checker.sv =====
// Port-level checks for the ordered list engine, bound to the top level.
// Depends on ole_pkg and ordered_list_engine_unit.
module ole_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic [ole_pkg::ST_W-1:0]   status,
    input logic [ole_pkg::LEN_W-1:0]  length
);
    import ole_pkg::*;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while busy");

    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted word neither started nor answered");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (length == LEN_W'(CAPACITY)))
        else $error("full status with list not at capacity");

    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> (length == '0))
        else $error("empty status with nonzero length");

endmodule

bind ordered_list_engine_unit ole_checker u_ole_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .status (status),
    .length (length)
);
